// ----- rtl/kmm_pkg.sv -----
// Shared types, constants and mapping functions for the key and mouse to multitouch mapper.
package kmm_pkg;

    localparam int MAX_RESULTS = 10;
    localparam logic [16:0] TRACKING_ID_MAX = 17'd65535;

    // Output event types and codes.
    localparam logic [1:0] T_SYN = 2'd0;
    localparam logic [1:0] T_ABS = 2'd3;
    localparam logic [5:0] C_REPORT = 6'd0;
    localparam logic [5:0] C_SLOT = 6'd47;
    localparam logic [5:0] C_MAJOR = 6'd48;
    localparam logic [5:0] C_X = 6'd53;
    localparam logic [5:0] C_Y = 6'd54;
    localparam logic [5:0] C_ID = 6'd57;
    localparam logic [16:0] VALUE_LIFT = 17'h1FFFF;

    // Input event types and codes.
    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_REL = 5'd2;
    localparam logic [8:0] SYNC_FRAME = 9'd0;
    localparam logic [8:0] REL_X = 9'd0;
    localparam logic [8:0] REL_Y = 9'd1;
    localparam logic [8:0] KEY_W = 9'd17;
    localparam logic [8:0] KEY_S = 9'd31;
    localparam logic [8:0] KEY_A = 9'd30;
    localparam logic [8:0] KEY_D = 9'd32;
    localparam logic [8:0] MOUSE_PRIMARY = 9'd272;
    localparam logic [8:0] MOUSE_SECONDARY = 9'd273;

    // Slots and fixed spots.
    localparam logic [3:0] PTR_SLOT = 4'd0;
    localparam logic [3:0] LEFT_SLOT = 4'd1;
    localparam logic [3:0] RIGHT_SLOT = 4'd2;
    localparam logic [3:0] JOY_SLOT = 4'd3;
    localparam logic [16:0] LEFT_X = 17'd800;
    localparam logic [16:0] LEFT_Y = 17'd380;
    localparam logic [16:0] RIGHT_X = 17'd550;
    localparam logic [16:0] RIGHT_Y = 17'd150;
    localparam logic [16:0] JOY_W_EXTRA = 17'd100;

    // Configuration register indexes and reset values.
    localparam logic [2:0] CFG_JOY_CX = 3'd0;
    localparam logic [2:0] CFG_JOY_CY = 3'd1;
    localparam logic [2:0] CFG_JOY_R = 3'd2;
    localparam logic [2:0] CFG_MAX_X = 3'd3;
    localparam logic [2:0] CFG_MAX_Y = 3'd4;
    localparam logic [2:0] CFG_HOME_X = 3'd5;
    localparam logic [2:0] CFG_HOME_Y = 3'd6;
    localparam logic [2:0] CFG_SIZE = 3'd7;
    localparam logic [11:0] JOY_CX_RST = 12'd813;
    localparam logic [11:0] JOY_CY_RST = 12'd1877;
    localparam logic [9:0] JOY_R_RST = 10'd250;
    localparam logic [11:0] MAX_X_RST = 12'd1079;
    localparam logic [11:0] MAX_Y_RST = 12'd2339;
    localparam logic [11:0] HOME_X_RST = 12'd540;
    localparam logic [11:0] HOME_Y_RST = 12'd1170;
    localparam logic [7:0] SIZE_RST = 8'd10;

    // Kinds of event group within one run.
    localparam logic [2:0] SEG_NONE = 3'd0;
    localparam logic [2:0] SEG_DOWN = 3'd1;
    localparam logic [2:0] SEG_UP = 3'd2;
    localparam logic [2:0] SEG_MOVE = 3'd3;
    localparam logic [2:0] SEG_PAIR = 3'd4;
    localparam logic [2:0] SEG_REPORT = 3'd5;

    typedef struct packed {
        logic        src;
        logic [4:0]  typ;
        logic [8:0]  code;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        logic [3:0]  held;
        logic [11:0] px;
        logic [11:0] py;
        logic [15:0] track;
    } t_state;

    typedef struct packed {
        logic [11:0] joy_cx;
        logic [11:0] joy_cy;
        logic [9:0]  joy_r;
        logic [11:0] max_x;
        logic [11:0] max_y;
        logic [11:0] home_x;
        logic [11:0] home_y;
        logic [7:0]  size;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  typ;
        logic [5:0]  code;
        logic [16:0] value;
    } t_ev;

    typedef t_ev [MAX_RESULTS-1:0] t_run;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [16:0] x;
        logic [16:0] y;
        logic        pair_y;
    } t_seg;

    typedef struct packed {
        logic [8:0]  code;
        logic [3:0]  slot;
        logic [11:0] x;
        logic [11:0] y;
    } t_btn_row;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic [11:0] x;
        logic [11:0] y;
    } t_btn;

    localparam t_btn_row BTN_MAP [8] = '{
        '{code: 9'd57, slot: 4'd4, x: 12'd732, y: 12'd160},
        '{code: 9'd46, slot: 4'd5, x: 12'd1013, y: 12'd372},
        '{code: 9'd44, slot: 4'd6, x: 12'd1000, y: 12'd206},
        '{code: 9'd19, slot: 4'd7, x: 12'd1012, y: 12'd542},
        '{code: 9'd16, slot: 4'd8, x: 12'd397, y: 12'd1984},
        '{code: 9'd18, slot: 4'd9, x: 12'd400, y: 12'd1835},
        '{code: 9'd2, slot: 4'd10, x: 12'd980, y: 12'd1301},
        '{code: 9'd3, slot: 4'd11, x: 12'd980, y: 12'd1056}
    };

    function automatic t_btn btn_lookup(input logic [8:0] code);
        t_btn b;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            if (code == BTN_MAP[i].code) begin
                b.hit = 1'b1;
                b.slot = BTN_MAP[i].slot;
                b.x = BTN_MAP[i].x;
                b.y = BTN_MAP[i].y;
            end
        end
        return b;
    endfunction

    function automatic logic [3:0] seg_len(input logic [2:0] kind);
        logic [3:0] n;
        case (kind)
            SEG_DOWN: n = 4'd6;
            SEG_UP: n = 4'd4;
            SEG_MOVE: n = 4'd4;
            SEG_PAIR: n = 4'd2;
            SEG_REPORT: n = 4'd1;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic t_ev seg_entry(input t_seg s, input logic [3:0] k,
                                      input logic [15:0] id, input logic [7:0] size);
        t_ev e;
        t_ev rep;
        e.typ = T_ABS;
        e.code = C_SLOT;
        e.value = {13'd0, s.slot};
        rep.typ = T_SYN;
        rep.code = C_REPORT;
        rep.value = '0;
        case (s.kind)
            SEG_DOWN: begin
                case (k)
                    4'd0: e.code = C_SLOT;
                    4'd1: begin
                        e.code = C_ID;
                        e.value = {1'b0, id};
                    end
                    4'd2: begin
                        e.code = C_X;
                        e.value = s.x;
                    end
                    4'd3: begin
                        e.code = C_Y;
                        e.value = s.y;
                    end
                    4'd4: begin
                        e.code = C_MAJOR;
                        e.value = {9'd0, size};
                    end
                    default: e = rep;
                endcase
            end
            SEG_UP: begin
                case (k)
                    4'd0: e.code = C_SLOT;
                    4'd1: begin
                        e.code = C_MAJOR;
                        e.value = '0;
                    end
                    4'd2: begin
                        e.code = C_ID;
                        e.value = VALUE_LIFT;
                    end
                    default: e = rep;
                endcase
            end
            SEG_MOVE: begin
                case (k)
                    4'd0: e.code = C_SLOT;
                    4'd1: begin
                        e.code = C_X;
                        e.value = s.x;
                    end
                    4'd2: begin
                        e.code = C_Y;
                        e.value = s.y;
                    end
                    default: e = rep;
                endcase
            end
            SEG_PAIR: begin
                case (k)
                    4'd0: e.code = C_SLOT;
                    default: begin
                        e.code = s.pair_y ? C_Y : C_X;
                        e.value = s.x;
                    end
                endcase
            end
            default: e = rep;
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/key_mouse_to_multitouch_mapper.sv -----
// Top level of the key and mouse to multitouch mapper: input register, result buffer, sequencer.
//
// Each accepted request is held in an input register and, in the cycle it leaves that register,
// is mapped in one pass into a buffer of up to ten multitouch events while the joystick flags,
// pointer position and tracking id are updated. The buffer is sent one event per cycle while
// m_axis_tready is high, the final event of a run carrying tlast, so a run holds one to ten
// events and a request that gives no result sends nothing. The first result is sent from the
// result buffer, after the request has passed the input register, and the next request is
// taken while the current run is still being sent. The output sequencer over the result buffer
// sets the sustained rate: a held request waits until the current run's last event has left.
module key_mouse_to_multitouch_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // event_type [4:0], event_code [13:5], event_value [29:14]
    input  logic        s_axis_tuser,   // source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_type [1:0], out_code [7:2], out_value [24:8]
    output logic        m_axis_tlast
);
    import kmm_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    t_item      r_in;
    t_run       r_run;
    t_run       n_run;
    logic [3:0] r_run_cnt;
    logic [3:0] n_run_cnt;
    logic       r_run_valid;
    logic [3:0] r_idx;
    logic       w_out_fire;
    logic       w_run_free;
    logic       w_load;
    t_ev        w_ev;

    kmm_event_map u_map (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_run   (n_run),
        .o_count (n_run_cnt),
        .o_state (n_state)
    );

    assign w_out_fire = m_axis_tvalid && m_axis_tready;
    assign w_run_free = !r_run_valid || (w_out_fire && m_axis_tlast);
    assign w_load = r_in_valid && w_run_free;
    assign s_axis_tready = !r_in_valid || w_load;

    assign w_ev = r_run[r_idx];
    assign m_axis_tvalid = r_run_valid;
    assign m_axis_tdata = {7'd0, w_ev.value, w_ev.code, w_ev.typ};
    assign m_axis_tlast = (r_idx == (r_run_cnt - 4'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{joy_cx: JOY_CX_RST, joy_cy: JOY_CY_RST, joy_r: JOY_R_RST,
                       max_x: MAX_X_RST, max_y: MAX_Y_RST, home_x: HOME_X_RST,
                       home_y: HOME_Y_RST, size: SIZE_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_JOY_CX: r_cfg.joy_cx <= i_cfg_data;
                CFG_JOY_CY: r_cfg.joy_cy <= i_cfg_data;
                CFG_JOY_R: r_cfg.joy_r <= i_cfg_data[9:0];
                CFG_MAX_X: r_cfg.max_x <= i_cfg_data;
                CFG_MAX_Y: r_cfg.max_y <= i_cfg_data;
                CFG_HOME_X: r_cfg.home_x <= i_cfg_data;
                CFG_HOME_Y: r_cfg.home_y <= i_cfg_data;
                CFG_SIZE: r_cfg.size <= i_cfg_data[7:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{held: 4'd0, px: HOME_X_RST, py: HOME_Y_RST, track: 16'd0};
            r_in_valid <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_cnt <= 4'd0;
            r_idx <= 4'd0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_load) begin
                r_state <= n_state;
                r_run_valid <= (n_run_cnt != 4'd0);
                r_run_cnt <= n_run_cnt;
                r_idx <= 4'd0;
            end else if (w_out_fire) begin
                if (m_axis_tlast) begin
                    r_run_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= '{src: s_axis_tuser, typ: s_axis_tdata[4:0], code: s_axis_tdata[13:5],
                      value: s_axis_tdata[29:14]};
        end
        if (w_load) begin
            r_run <= n_run;
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_idx < r_run_cnt))
        else $error("Run index has passed the end of the run.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> ((r_run_cnt != 4'd0) && (r_run_cnt <= 4'(MAX_RESULTS))))
        else $error("Run length out of range.");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !m_axis_tlast) |=> (m_axis_tvalid && (r_idx == $past(r_idx) + 4'd1)))
        else $error("Run stopped or skipped before its last event.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_idx)))
        else $error("Stalled run moved on.");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_run_free) |=> r_in_valid)
        else $error("Pending request lost while the run was busy.");

endmodule

// ----- rtl/kmm_event_map.sv -----
// Single-pass mapping of one input event to its run of multitouch events and the next state.
module kmm_event_map (
    input  kmm_pkg::t_item  i_item,
    input  kmm_pkg::t_state i_state,
    input  kmm_pkg::t_cfg   i_cfg,
    output kmm_pkg::t_run   o_run,
    output logic [3:0]      o_count,
    output kmm_pkg::t_state o_state
);
    import kmm_pkg::*;

    t_seg        seg0;
    t_seg        seg1;
    t_seg        seg2;
    t_btn        btn;
    logic        is_key;
    logic        v1;
    logic        v0;
    logic        dir_hit;
    logic [3:0]  dir_mask;
    logic [3:0]  held_n;
    logic        need_id;
    logic [16:0] id_inc;
    logic [15:0] id_new;
    logic [16:0] cx;
    logic [16:0] cy;
    logic [16:0] cr;
    logic [16:0] cx_m;
    logic [16:0] cx_p;
    logic [16:0] cy_m;
    logic [16:0] cy_p;
    logic [16:0] cx_w;
    logic [17:0] val_sx;
    logic [17:0] py_new;
    logic [17:0] px_new;
    logic        py_out;
    logic        px_out;
    logic [3:0]  len0;
    logic [3:0]  len01;
    logic [3:0]  len2;

    assign is_key = (i_item.typ == EV_KEY);
    assign v1 = (i_item.value == 16'd1);
    assign v0 = (i_item.value == 16'd0);
    assign btn = btn_lookup(i_item.code);

    assign cx = {5'd0, i_cfg.joy_cx};
    assign cy = {5'd0, i_cfg.joy_cy};
    assign cr = {7'd0, i_cfg.joy_r};
    assign cx_m = cx - cr;
    assign cx_p = cx + cr;
    assign cy_m = cy - cr;
    assign cy_p = cy + cr;
    assign cx_w = cx_m - JOY_W_EXTRA;

    assign val_sx = {{2{i_item.value[15]}}, i_item.value};
    assign py_new = {6'd0, i_state.py} - val_sx;
    assign px_new = {6'd0, i_state.px} + val_sx;
    assign py_out = py_new[17] || (py_new[16:0] > {5'd0, i_cfg.max_y});
    assign px_out = px_new[17] || (px_new[16:0] > {5'd0, i_cfg.max_x});

    assign id_inc = {1'b0, i_state.track} + 17'd1;
    assign id_new = (id_inc > TRACKING_ID_MAX) ? 16'd0 : id_inc[15:0];

    always_comb begin
        seg0 = '0;
        seg1 = '0;
        seg2 = '0;
        dir_hit = 1'b0;
        dir_mask = 4'd0;
        held_n = i_state.held;
        need_id = 1'b0;
        o_state = i_state;

        if (i_item.src == 1'b0) begin
            if (is_key) begin
                case (i_item.code)
                    KEY_W: begin
                        dir_hit = 1'b1;
                        dir_mask = 4'b0001;
                    end
                    KEY_S: begin
                        dir_hit = 1'b1;
                        dir_mask = 4'b0010;
                    end
                    KEY_A: begin
                        dir_hit = 1'b1;
                        dir_mask = 4'b0100;
                    end
                    KEY_D: begin
                        dir_hit = 1'b1;
                        dir_mask = 4'b1000;
                    end
                    default: dir_hit = 1'b0;
                endcase
            end
            if (dir_hit && v1 && (i_state.held == 4'd0)) begin
                seg0 = '{kind: SEG_DOWN, slot: JOY_SLOT, x: cx, y: cy, pair_y: 1'b0};
                need_id = 1'b1;
            end
            if (dir_hit && v1) begin
                held_n = i_state.held | dir_mask;
            end else if (dir_hit && v0) begin
                held_n = i_state.held & ~dir_mask;
            end
            seg1.kind = SEG_MOVE;
            seg1.slot = JOY_SLOT;
            if (held_n[0] && held_n[2]) begin
                seg1.x = cx_m;
                seg1.y = cy_p;
            end else if (held_n[0] && held_n[3]) begin
                seg1.x = cx_m;
                seg1.y = cy_m;
            end else if (held_n[1] && held_n[2]) begin
                seg1.x = cx_p;
                seg1.y = cy_p;
            end else if (held_n[1] && held_n[3]) begin
                seg1.x = cx_p;
                seg1.y = cy_m;
            end else if (held_n[0]) begin
                seg1.x = cx_w;
                seg1.y = cy;
            end else if (held_n[1]) begin
                seg1.x = cx_p;
                seg1.y = cy;
            end else if (held_n[2]) begin
                seg1.x = cx;
                seg1.y = cy_p;
            end else if (held_n[3]) begin
                seg1.x = cx;
                seg1.y = cy_m;
            end else begin
                seg1.kind = SEG_UP;
            end
            if (is_key && btn.hit) begin
                seg2.slot = btn.slot;
                seg2.x = {5'd0, btn.x};
                seg2.y = {5'd0, btn.y};
                if (v1) begin
                    seg2.kind = SEG_DOWN;
                    need_id = 1'b1;
                end else if (v0) begin
                    seg2.kind = SEG_UP;
                end
            end
            o_state.held = held_n;
        end else begin
            case (i_item.typ)
                EV_KEY: begin
                    if ((i_item.code == MOUSE_PRIMARY) || (i_item.code == MOUSE_SECONDARY)) begin
                        if (i_item.code == MOUSE_PRIMARY) begin
                            seg0 = '{kind: SEG_NONE, slot: LEFT_SLOT, x: LEFT_X, y: LEFT_Y,
                                     pair_y: 1'b0};
                        end else begin
                            seg0 = '{kind: SEG_NONE, slot: RIGHT_SLOT, x: RIGHT_X,
                                     y: RIGHT_Y, pair_y: 1'b0};
                        end
                        if (v1) begin
                            seg0.kind = SEG_DOWN;
                            need_id = 1'b1;
                        end else if (v0) begin
                            seg0.kind = SEG_UP;
                        end
                    end
                end
                EV_REL: begin
                    if ((i_item.code == REL_X) || (i_item.code == REL_Y)) begin
                        if ((i_item.code == REL_X) ? py_out : px_out) begin
                            seg0.kind = SEG_UP;
                            seg0.slot = PTR_SLOT;
                            seg1 = '{kind: SEG_DOWN, slot: PTR_SLOT,
                                     x: {5'd0, i_cfg.home_x}, y: {5'd0, i_cfg.home_y},
                                     pair_y: 1'b0};
                            need_id = 1'b1;
                            o_state.px = i_cfg.home_x;
                            o_state.py = i_cfg.home_y;
                        end else if (i_item.code == REL_X) begin
                            seg0 = '{kind: SEG_PAIR, slot: PTR_SLOT,
                                     x: {5'd0, py_new[11:0]}, y: '0, pair_y: 1'b1};
                            o_state.py = py_new[11:0];
                        end else begin
                            seg0 = '{kind: SEG_PAIR, slot: PTR_SLOT,
                                     x: {5'd0, px_new[11:0]}, y: '0, pair_y: 1'b0};
                            o_state.px = px_new[11:0];
                        end
                    end
                end
                EV_SYN: begin
                    if (i_item.code == SYNC_FRAME) begin
                        seg0.kind = SEG_REPORT;
                    end
                end
                default: seg0.kind = SEG_NONE;
            endcase
        end

        if (need_id) begin
            o_state.track = id_new;
        end
    end

    assign len0 = seg_len(seg0.kind);
    assign len01 = len0 + seg_len(seg1.kind);
    assign len2 = seg_len(seg2.kind);
    assign o_count = len01 + len2;

    always_comb begin
        logic [3:0] j;
        for (int n = 0; n < MAX_RESULTS; n++) begin
            j = 4'(n);
            if (j < len0) begin
                o_run[n] = seg_entry(seg0, j, id_new, i_cfg.size);
            end else if (j < len01) begin
                o_run[n] = seg_entry(seg1, j - len0, id_new, i_cfg.size);
            end else begin
                o_run[n] = seg_entry(seg2, j - len01, id_new, i_cfg.size);
            end
        end
    end

endmodule
